[rtl/ssub_pkg.sv]
// Shared types and constants of the service subscriber table.
package ssub_pkg;

    localparam int TABLE_SLOTS_DEF = 16;
    localparam int OPTION_LIMIT    = 16;
    localparam int MAX_RESULTS     = 16;
    localparam int CNT_W           = $clog2(MAX_RESULTS + 1);

    localparam logic CMD_SUBSCRIBE = 1'b0;
    localparam logic CMD_NOTIFY    = 1'b1;

    localparam logic [7:0]  KIND_V4_ENDPOINT  = 8'h04;
    localparam logic [7:0]  KIND_V4_MULTICAST = 8'h14;
    localparam logic [7:0]  PROTO_UDP         = 8'h11;
    localparam logic [7:0]  PROTO_TCP         = 8'h06;
    localparam logic [15:0] MIN_OPTION_SIZE   = 16'd9;

    localparam logic [2:0] ST_ADDED       = 3'd0;
    localparam logic [2:0] ST_ALREADY     = 3'd1;
    localparam logic [2:0] ST_NO_ENDPOINT = 3'd2;
    localparam logic [2:0] ST_FULL        = 3'd3;
    localparam logic [2:0] ST_TARGET      = 3'd4;
    localparam logic [2:0] ST_NONE        = 3'd5;

    typedef struct packed {
        logic        valid;
        logic [31:0] ip;
        logic [15:0] port;
        logic [15:0] service;
        logic [15:0] inst_id;
        logic [15:0] eventgroup;
    } entry_t;

    typedef struct packed {
        logic shift;
        logic set_valid;
    } ring_ctl_t;

endpackage

[rtl/ssub_cell.sv]
// One table slot of the subscriber ring.
module ssub_cell #(
    parameter int IDX_W      = 4,
    parameter int SLOT_INDEX = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ssub_pkg::ring_ctl_t ctl,
    input  logic [IDX_W-1:0]    set_slot,
    input  ssub_pkg::entry_t    entry_in,
    output ssub_pkg::entry_t    entry_out
);
    import ssub_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    entry_t      data_reg;
    logic        hit_self;

    assign hit_self = ctl.set_valid && (set_slot == IDX_W'(SLOT_INDEX));

    always_comb
    begin
        valid_next = valid_reg;
        if (hit_self)
        begin
            valid_next = 1'b1;
        end
        else if (ctl.shift)
        begin
            valid_next = entry_in.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload travels with the ring, no reset
    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            data_reg <= entry_in;
        end
    end

    always_comb
    begin
        entry_out       = data_reg;
        entry_out.valid = valid_reg;
    end

endmodule

[rtl/ssub_ctrl.sv]
// Scan controller: watches the ring head, decides and emits results.
module ssub_ctrl #(
    parameter int TABLE_SLOTS = ssub_pkg::TABLE_SLOTS_DEF,
    parameter int IDX_W       = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                command,
    input  logic [31:0]         endpoint_ip,
    input  logic [15:0]         endpoint_port,
    input  logic [7:0]          transport_protocol,
    input  logic [7:0]          option_kind,
    input  logic [15:0]         option_size,
    input  logic [3:0]          first_option_count,
    input  logic [7:0]          first_option_index,
    input  logic [4:0]          options_available,
    input  logic [15:0]         svc_id,
    input  logic [15:0]         inst_id,
    input  logic [15:0]         group_id,
    input  ssub_pkg::entry_t    head,
    output ssub_pkg::entry_t    tail,
    output ssub_pkg::ring_ctl_t ctl,
    output logic [IDX_W-1:0]    set_slot,
    output logic                result_valid,
    output logic [2:0]          status,
    output logic [3:0]          slot,
    output logic [31:0]         target_ip,
    output logic [15:0]         target_port,
    output logic                last
);
    import ssub_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic             cmd_reg, cmd_next;
    entry_t           key_reg, key_next;
    logic             dup_reg, dup_next;
    logic [IDX_W-1:0] dup_slot_reg, dup_slot_next;
    logic             free_reg, free_next;
    logic [IDX_W-1:0] free_slot_reg, free_slot_next;
    logic             pend_reg, pend_next;
    logic [IDX_W-1:0] pend_slot_reg, pend_slot_next;
    logic [31:0]      pend_ip_reg, pend_ip_next;
    logic [15:0]      pend_port_reg, pend_port_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic             rv_reg, rv_next;
    logic [2:0]       status_reg, status_next;
    logic [IDX_W-1:0] rslot_reg, rslot_next;
    logic [31:0]      rip_reg, rip_next;
    logic [15:0]      rport_reg, rport_next;
    logic             last_reg, last_next;

    logic [8:0]       avail_c;
    logic             ep_ok;
    logic             kind_ok;
    logic             head_dup;
    logic             head_free;
    logic             head_hit;
    logic             set_valid;
    logic [IDX_W+3:0] slot_ext;

    // endpoint check on the incoming fields
    always_comb
    begin
        if ({4'b0, options_available} > 9'(OPTION_LIMIT))
        begin
            avail_c = 9'(OPTION_LIMIT);
        end
        else
        begin
            avail_c = {4'b0, options_available};
        end
        kind_ok = 1'b0;
        if (option_kind == KIND_V4_ENDPOINT)
        begin
            kind_ok = (transport_protocol == PROTO_UDP) ||
                      (transport_protocol == PROTO_TCP);
        end
        else if (option_kind == KIND_V4_MULTICAST)
        begin
            kind_ok = (transport_protocol == PROTO_UDP);
        end
        ep_ok = (first_option_count != 4'd0) &&
                ({1'b0, first_option_index} < avail_c) &&
                (option_size >= MIN_OPTION_SIZE) && kind_ok;
    end

    assign head_dup  = head.valid && (head.ip == key_reg.ip) &&
                       (head.port == key_reg.port) &&
                       (head.service == key_reg.service) &&
                       (head.eventgroup == key_reg.eventgroup);
    assign head_free = !head.valid;
    assign head_hit  = head.valid && (head.service == key_reg.service);

    // drop the new entry into the first free slot as it passes; it stays
    // invalid until the scan confirms no duplicate
    always_comb
    begin
        tail = head;
        if ((state_reg == S_SCAN) && (cmd_reg == CMD_SUBSCRIBE) && head_free && !free_reg)
        begin
            tail       = key_reg;
            tail.valid = 1'b0;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        dup_next       = dup_reg;
        dup_slot_next  = dup_slot_reg;
        free_next      = free_reg;
        free_slot_next = free_slot_reg;
        pend_next      = pend_reg;
        pend_slot_next = pend_slot_reg;
        pend_ip_next   = pend_ip_reg;
        pend_port_next = pend_port_reg;
        cnt_next       = cnt_reg;
        rv_next        = 1'b0;
        status_next    = status_reg;
        rslot_next     = rslot_reg;
        rip_next       = rip_reg;
        rport_next     = rport_reg;
        last_next      = last_reg;
        set_valid      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next            = command;
                    key_next.valid      = 1'b1;
                    key_next.ip         = endpoint_ip;
                    key_next.port       = endpoint_port;
                    key_next.service    = svc_id;
                    key_next.inst_id    = inst_id;
                    key_next.eventgroup = group_id;
                    if ((command == CMD_NOTIFY) || ep_ok)
                    begin
                        state_next = S_SCAN;
                        k_next     = '0;
                        dup_next   = 1'b0;
                        free_next  = 1'b0;
                        pend_next  = 1'b0;
                        cnt_next   = '0;
                    end
                    else
                    begin
                        rv_next     = 1'b1;
                        status_next = ST_NO_ENDPOINT;
                        rslot_next  = '0;
                        rip_next    = '0;
                        rport_next  = '0;
                        last_next   = 1'b1;
                    end
                end
            end
            S_SCAN:
            begin
                if (cmd_reg == CMD_SUBSCRIBE)
                begin
                    if (head_dup && !dup_reg)
                    begin
                        dup_next      = 1'b1;
                        dup_slot_next = k_reg;
                    end
                    if (head_free && !free_reg)
                    begin
                        free_next      = 1'b1;
                        free_slot_next = k_reg;
                    end
                end
                else if (head_hit && (cnt_reg < CNT_W'(MAX_RESULTS)))
                begin
                    // release the held target, hold the new one
                    if (pend_reg)
                    begin
                        rv_next     = 1'b1;
                        status_next = ST_TARGET;
                        rslot_next  = pend_slot_reg;
                        rip_next    = pend_ip_reg;
                        rport_next  = pend_port_reg;
                        last_next   = 1'b0;
                    end
                    pend_next      = 1'b1;
                    pend_slot_next = k_reg;
                    pend_ip_next   = head.ip;
                    pend_port_next = head.port;
                    cnt_next       = cnt_reg + CNT_W'(1);
                end
                if (k_reg == IDX_W'(TABLE_SLOTS - 1))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    k_next = k_reg + IDX_W'(1);
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
                rv_next    = 1'b1;
                last_next  = 1'b1;
                rslot_next = '0;
                rip_next   = '0;
                rport_next = '0;
                if (cmd_reg == CMD_SUBSCRIBE)
                begin
                    if (dup_reg)
                    begin
                        status_next = ST_ALREADY;
                        rslot_next  = dup_slot_reg;
                    end
                    else if (free_reg)
                    begin
                        status_next = ST_ADDED;
                        rslot_next  = free_slot_reg;
                        set_valid   = 1'b1;
                    end
                    else
                    begin
                        status_next = ST_FULL;
                    end
                end
                else if (pend_reg)
                begin
                    status_next = ST_TARGET;
                    rslot_next  = pend_slot_reg;
                    rip_next    = pend_ip_reg;
                    rport_next  = pend_port_reg;
                end
                else
                begin
                    status_next = ST_NONE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg     <= '0;
            cmd_reg   <= CMD_SUBSCRIBE;
            dup_reg   <= 1'b0;
            free_reg  <= 1'b0;
            pend_reg  <= 1'b0;
            cnt_reg   <= '0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            cmd_reg   <= cmd_next;
            dup_reg   <= dup_next;
            free_reg  <= free_next;
            pend_reg  <= pend_next;
            cnt_reg   <= cnt_next;
            rv_reg    <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        dup_slot_reg  <= dup_slot_next;
        free_slot_reg <= free_slot_next;
        pend_slot_reg <= pend_slot_next;
        pend_ip_reg   <= pend_ip_next;
        pend_port_reg <= pend_port_next;
        status_reg    <= status_next;
        rslot_reg     <= rslot_next;
        rip_reg       <= rip_next;
        rport_reg     <= rport_next;
        last_reg      <= last_next;
    end

    assign ctl.shift     = (state_reg == S_SCAN);
    assign ctl.set_valid = set_valid;
    assign set_slot      = free_slot_reg;
    assign busy          = (state_reg != S_IDLE);

    assign slot_ext     = {4'b0, rslot_reg};
    assign result_valid = rv_reg;
    assign status       = status_reg;
    assign slot         = slot_ext[3:0];
    assign target_ip    = rip_reg;
    assign target_port  = rport_reg;
    assign last         = last_reg;

endmodule

[rtl/service_subscriber_table.sv]
// Top level of the service subscriber table: slot ring and scan controller.
//
// A transaction is taken when start is high and busy is low. A subscribe
// with an unusable endpoint answers on the next cycle and leaves busy low.
// Every other transaction scans the table: the slots sit in a ring of
// cells that rotates once through the single compare unit at its head,
// one slot per cycle, followed by a decision state; busy stays high over
// that time. Results show for one cycle each, marked by result_valid, and
// cannot be held off: the receiver must take them as they come. A notify
// gives its targets in slot order while the ring rotates and the last one
// on the cycle after the decision state, when busy has already dropped;
// slot reports the low four bits of the slot number.
module service_subscriber_table #(
    parameter int TABLE_SLOTS = ssub_pkg::TABLE_SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        command,
    input  logic [31:0] endpoint_ip,
    input  logic [15:0] endpoint_port,
    input  logic [7:0]  transport_protocol,
    input  logic [7:0]  option_kind,
    input  logic [15:0] option_size,
    input  logic [3:0]  first_option_count,
    input  logic [7:0]  first_option_index,
    input  logic [4:0]  options_available,
    input  logic [15:0] svc_id,
    input  logic [15:0] inst_id,
    input  logic [15:0] group_id,
    output logic        result_valid,
    output logic [2:0]  status,
    output logic [3:0]  slot,
    output logic [31:0] target_ip,
    output logic [15:0] target_port,
    output logic        last
);
    import ssub_pkg::*;

    localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

    entry_t           ring [TABLE_SLOTS];
    entry_t           tail;
    ring_ctl_t        ctl;
    logic [IDX_W-1:0] set_slot;

    // each cell takes its upper neighbor; the last cell takes the write-back
    for (genvar i = 0; i < TABLE_SLOTS; i++)
    begin : g_cell
        entry_t cell_in;
        if (i == TABLE_SLOTS - 1)
        begin : g_end
            assign cell_in = tail;
        end
        else
        begin : g_mid
            assign cell_in = ring[i + 1];
        end

        ssub_cell #(
            .IDX_W      (IDX_W),
            .SLOT_INDEX (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .set_slot  (set_slot),
            .entry_in  (cell_in),
            .entry_out (ring[i])
        );
    end

    ssub_ctrl #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .IDX_W       (IDX_W)
    ) u_ctrl (
        .clk                (clk),
        .rst_n              (rst_n),
        .start              (start),
        .busy               (busy),
        .command            (command),
        .endpoint_ip        (endpoint_ip),
        .endpoint_port      (endpoint_port),
        .transport_protocol (transport_protocol),
        .option_kind        (option_kind),
        .option_size        (option_size),
        .first_option_count (first_option_count),
        .first_option_index (first_option_index),
        .options_available  (options_available),
        .svc_id             (svc_id),
        .inst_id            (inst_id),
        .group_id           (group_id),
        .head               (ring[0]),
        .tail               (tail),
        .ctl                (ctl),
        .set_slot           (set_slot),
        .result_valid       (result_valid),
        .status             (status),
        .slot               (slot),
        .target_ip          (target_ip),
        .target_port        (target_port),
        .last               (last)
    );

endmodule
